/* design/mrc_pkg.sv */
// ----------------------------------------------------------------------------
// mrc_pkg
// Shared types, status codes and the CRC-16 byte update for the Modbus RTU
// response checker.
// ----------------------------------------------------------------------------
package mrc_pkg;

	localparam logic [15:0] CRC_POLY = 16'hA001;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;

	localparam logic [2:0] ST_OK    = 3'd0;
	localparam logic [2:0] ST_SHORT = 3'd1;
	localparam logic [2:0] ST_CRC   = 3'd2;
	localparam logic [2:0] ST_ADDR  = 3'd3;
	localparam logic [2:0] ST_EXC   = 3'd4;
	localparam logic [2:0] ST_FUNC  = 3'd5;
	localparam logic [2:0] ST_LEN   = 3'd6;

	localparam logic [1:0] REG_DEVICE_ADDRESS = 2'd0;
	localparam logic [1:0] REG_EXPECTED_FUNC  = 2'd1;
	localparam logic [1:0] REG_PAYLOAD_LEN    = 2'd2;
	localparam logic [1:0] REG_CRC_HIGH_FIRST = 2'd3;

	typedef struct packed {
		logic [7:0] device_address;
		logic [6:0] expected_function;
		logic [7:0] expected_payload_len;
		logic       crc_high_first;
	} cfg_t;

	typedef struct packed {
		logic       valid;
		logic       payload_valid;
		logic [7:0] payload_byte;
		logic       done_res;
		logic [2:0] status;
		logic [7:0] exception_code;
	} result_t;

	function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
		input logic [7:0] data);
		logic [15:0] c;
		c = crc_in ^ {8'h00, data};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

/* design/modbus_rtu_response_checker.sv */
// ----------------------------------------------------------------------------
// modbus_rtu_response_checker
// Takes one frame byte per transfer and sustains one byte per clock cycle.
// A byte is first taken into the input register, then the CRC update, payload
// hold line and frame checks run combinationally into the output register,
// so a byte's result is held in the output register. Payload bytes leave
// two bytes behind their arrival, and the byte flagged by tlast yields the
// frame status. The input side stalls only while the output register holds a
// result that downstream has not taken.
// ----------------------------------------------------------------------------
module modbus_rtu_response_checker #(
	parameter int MAX_FRAME = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  logic        s_tlast,   // frame_end
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [7:0] payload_byte, [10:8] status,
	                               // [18:11] exception_code, [23:19] zero
	output logic        m_tuser,   // payload_valid
	output logic        m_tlast,   // done_res
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);
	import mrc_pkg::*;

	cfg_t    cfg;
	result_t res;
	result_t res_gated;
	result_t out_q;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       advance;

	mrc_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	mrc_frame_proc #(.MAX_FRAME(MAX_FRAME)) u_proc (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (valid_s1 & advance),
		.rx_byte  (byte_s1),
		.frame_end(last_s1),
		.cfg      (cfg),
		.res      (res)
	);

	assign advance  = !out_q.valid || m_tready;
	assign s_tready = !valid_s1 || advance;

	always_comb begin
		res_gated       = res;
		res_gated.valid = valid_s1 & res.valid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_q <= '0;
		end else if (advance) begin
			out_q <= res_gated;
		end
	end

	assign m_tvalid = out_q.valid;
	assign m_tuser  = out_q.payload_valid;
	assign m_tlast  = out_q.done_res;
	assign m_tdata  = {5'd0, out_q.exception_code, out_q.status, out_q.payload_byte};

	a_result_has_meaning: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser || m_tlast))
		else $error("result carries neither payload nor status");

	a_status_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tlast) |-> (m_tdata[10:8] == ST_OK))
		else $error("status reported before frame end");

	a_exc_only_with_status: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[10:8] != ST_EXC) |-> (m_tdata[18:11] == 8'h00))
		else $error("exception code without exception status");

	a_s1_held_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(byte_s1) && $stable(last_s1)))
		else $error("input stage lost a byte while stalled");

endmodule

/* design/mrc_cfg_regs.sv */
// ----------------------------------------------------------------------------
// mrc_cfg_regs
// Configuration register file, written through a valid/ready channel.
// ----------------------------------------------------------------------------
module mrc_cfg_regs (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [7:0]   cfg_data,
	output mrc_pkg::cfg_t cfg
);
	import mrc_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.device_address       <= 8'd1;
			cfg_q.expected_function    <= 7'd3;
			cfg_q.expected_payload_len <= 8'd0;
			cfg_q.crc_high_first       <= 1'b1;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_DEVICE_ADDRESS: cfg_q.device_address       <= cfg_data;
				REG_EXPECTED_FUNC:  cfg_q.expected_function    <= cfg_data[6:0];
				REG_PAYLOAD_LEN:    cfg_q.expected_payload_len <= cfg_data;
				REG_CRC_HIGH_FIRST: cfg_q.crc_high_first       <= cfg_data[0];
				default: ;
			endcase
		end
	end

endmodule

/* design/mrc_frame_proc.sv */
// ----------------------------------------------------------------------------
// mrc_frame_proc
// Per-frame state: running CRC, byte count, two-byte hold line and header
// bytes. Produces the result of the byte being stepped in.
// ----------------------------------------------------------------------------
module mrc_frame_proc #(
	parameter int MAX_FRAME = 256
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            step,
	input  logic [7:0]      rx_byte,
	input  logic            frame_end,
	input  mrc_pkg::cfg_t   cfg,
	output mrc_pkg::result_t res
);
	import mrc_pkg::*;

	localparam int CW = $clog2(MAX_FRAME + 2);
	localparam int LW = (CW > 8) ? CW : 8;
	localparam logic [CW-1:0] CNT_SAT = CW'(MAX_FRAME + 1);
	localparam logic [CW-1:0] CNT_MAX = CW'(MAX_FRAME);

	logic [15:0]   crc_q;
	logic [CW-1:0] count_q;
	logic [7:0]    held0_q;
	logic [7:0]    held1_q;
	logic [7:0]    addr_q;
	logic [7:0]    func_q;
	logic [7:0]    third_q;

	logic [15:0]   crc_nx;
	logic [CW-1:0] count_nx;
	logic          past_hdr;
	logic          pvalid;
	logic          crc_ok;
	logic [LW-1:0] pay_len;
	logic [2:0]    status;
	logic [7:0]    exc;

	assign past_hdr = (count_q >= CW'(2));
	assign pvalid   = (count_q >= CW'(4));
	assign crc_nx   = past_hdr ? crc16_byte(crc_q, held1_q) : crc_q;
	assign count_nx = (count_q < CNT_SAT) ? count_q + CW'(1) : count_q;
	assign pay_len  = LW'(count_nx) - LW'(4);
	assign crc_ok   = cfg.crc_high_first ?
		(held0_q == crc_nx[15:8] && rx_byte == crc_nx[7:0]) :
		(held0_q == crc_nx[7:0] && rx_byte == crc_nx[15:8]);

	always_comb begin
		status = ST_OK;
		exc    = 8'h00;
		if (count_nx < CW'(4)) begin
			status = ST_SHORT;
		end else if (!crc_ok) begin
			status = ST_CRC;
		end else if (addr_q != cfg.device_address) begin
			status = ST_ADDR;
		end else if (func_q != {1'b0, cfg.expected_function}) begin
			if (func_q == {1'b1, cfg.expected_function}) begin
				status = ST_EXC;
				exc    = third_q;
			end else begin
				status = ST_FUNC;
			end
		end else if (count_nx > CNT_MAX || pay_len != LW'(cfg.expected_payload_len)) begin
			status = ST_LEN;
		end
	end

	always_comb begin
		res.valid          = pvalid | frame_end;
		res.payload_valid  = pvalid;
		res.payload_byte   = pvalid ? held1_q : 8'h00;
		res.done_res       = frame_end;
		res.status         = frame_end ? status : ST_OK;
		res.exception_code = frame_end ? exc : 8'h00;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q   <= CRC_INIT;
			count_q <= '0;
			held0_q <= 8'h00;
			held1_q <= 8'h00;
			addr_q  <= 8'h00;
			func_q  <= 8'h00;
			third_q <= 8'h00;
		end else if (step) begin
			if (frame_end) begin
				crc_q   <= CRC_INIT;
				count_q <= '0;
				held0_q <= 8'h00;
				held1_q <= 8'h00;
				addr_q  <= 8'h00;
				func_q  <= 8'h00;
				third_q <= 8'h00;
			end else begin
				crc_q   <= crc_nx;
				count_q <= count_nx;
				held0_q <= rx_byte;
				held1_q <= held0_q;
				if (count_q == CW'(0)) begin
					addr_q <= rx_byte;
				end
				if (count_q == CW'(1)) begin
					func_q <= rx_byte;
				end
				if (count_q == CW'(2)) begin
					third_q <= rx_byte;
				end
			end
		end
	end

endmodule

/* sim/tb_modbus_rtu_response_checker.sv */
// ----------------------------------------------------------------------------
// tb_modbus_rtu_response_checker
// Self-checking testbench for the Modbus RTU response checker. Frames are
// sent one byte per transfer with random gaps, and results are taken with
// random stalls. A behavioral model of the CRC-16 checker predicts every
// payload byte and frame status, which are compared field by field. Directed
// tests cover reset settings, short frames, each status code and overlong
// frames; a random test runs many register settings with mostly well-formed
// frames mixed with corrupted frames and noise.
// ----------------------------------------------------------------------------
module tb_modbus_rtu_response_checker;

	timeunit 1ns;
	timeprecision 1ps;

	import mrc_pkg::*;

	localparam int MAX_FRAME      = 256;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 8;
	localparam int RANDOM_ITEMS   = 320;
	localparam int PHASE_ITEMS    = 120;

	typedef struct {
		logic       payload_valid;
		logic [7:0] payload_byte;
		logic       done_res;
		logic [2:0] status;
		logic [7:0] exception_code;
	} frame_result_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [7:0]  cfg_data;

	frame_result_t expected_results[$];
	logic [7:0]    frame_bytes[$];
	cfg_t          cfg_shadow;

	logic [15:0] crc_acc;
	int unsigned byte_pos;
	logic [7:0]  hold_new;
	logic [7:0]  hold_old;
	logic [7:0]  addr_seen;
	logic [7:0]  func_seen;
	logic [7:0]  third_seen;

	int  mismatches;
	int  bytes_accepted;
	bit  tx_idle_on;
	bit  rx_idle_on;

	modbus_rtu_response_checker #(
		.MAX_FRAME(MAX_FRAME)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] d);
		logic [15:0] c;
		c = crc ^ {8'h00, d};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

	task automatic clear_frame_state();
		crc_acc    = CRC_INIT;
		byte_pos   = 0;
		hold_new   = 8'h00;
		hold_old   = 8'h00;
		addr_seen  = 8'h00;
		func_seen  = 8'h00;
		third_seen = 8'h00;
	endtask

	task automatic predict_byte(input logic [7:0] b, input logic last);
		frame_result_t r;
		int unsigned   n;
		logic          crc_ok;
		r = '{default: '0};
		if (byte_pos >= 2) begin
			crc_acc = crc_update(crc_acc, hold_old);
			if (byte_pos >= 4) begin
				r.payload_valid = 1'b1;
				r.payload_byte  = hold_old;
			end
		end
		hold_old = hold_new;
		hold_new = b;
		case (byte_pos)
			0: addr_seen = b;
			1: func_seen = b;
			2: third_seen = b;
			default: ;
		endcase
		if (byte_pos < MAX_FRAME + 1) begin
			byte_pos++;
		end
		if (last) begin
			n = byte_pos;
			r.done_res = 1'b1;
			if (n < 4) begin
				r.status = ST_SHORT;
			end else begin
				if (cfg_shadow.crc_high_first) begin
					crc_ok = (hold_old == crc_acc[15:8]) && (hold_new == crc_acc[7:0]);
				end else begin
					crc_ok = (hold_old == crc_acc[7:0]) && (hold_new == crc_acc[15:8]);
				end
				if (!crc_ok) begin
					r.status = ST_CRC;
				end else if (addr_seen != cfg_shadow.device_address) begin
					r.status = ST_ADDR;
				end else if (func_seen != {1'b0, cfg_shadow.expected_function}) begin
					if (func_seen == {1'b1, cfg_shadow.expected_function}) begin
						r.status         = ST_EXC;
						r.exception_code = third_seen;
					end else begin
						r.status = ST_FUNC;
					end
				end else if (n > MAX_FRAME || n - 4 != cfg_shadow.expected_payload_len) begin
					r.status = ST_LEN;
				end else begin
					r.status = ST_OK;
				end
			end
			clear_frame_state();
		end
		if (r.payload_valid || r.done_res) begin
			expected_results.push_back(r);
		end
	endtask

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (want !== got) begin
			$display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
			mismatches++;
		end
	endtask

	initial begin
		int            stall;
		frame_result_t want;
		stall    = 0;
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) begin
				if (expected_results.size() == 0) begin
					$display("%0t ns: unexpected result, expected none, actual tdata %h tuser %b tlast %b",
						$time, m_tdata, m_tuser, m_tlast);
					mismatches++;
				end else begin
					want = expected_results.pop_front();
					check_field("payload_valid", 8'(want.payload_valid), 8'(m_tuser));
					check_field("payload_byte", want.payload_byte, m_tdata[7:0]);
					check_field("done_res", 8'(want.done_res), 8'(m_tlast));
					check_field("status", 8'(want.status), 8'(m_tdata[10:8]));
					check_field("exception_code", want.exception_code, m_tdata[18:11]);
				end
				stall = rx_idle_on ? $urandom_range(0, 11) : 0;
			end
			@(negedge clk);
			if (stall > 0) begin
				m_tready <= 1'b0;
				stall--;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin
		int idle;
		idle = 0;
		while (idle < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
				idle = 0;
			end else begin
				idle++;
			end
		end
		$display("Test completed with failures");
		$finish;
	end

	task automatic send_byte(input logic [7:0] b, input logic last);
		int gap;
		gap = tx_idle_on ? $urandom_range(0, 11) : 0;
		repeat (gap) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict_byte(b, last);
		bytes_accepted++;
	endtask

	task automatic send_frame();
		foreach (frame_bytes[i]) begin
			send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
		end
	endtask

	// Builds address, function and payload, then appends the CRC in the order
	// that the block is set to. A corrupted frame gets one bit flipped.
	task automatic build_frame(input logic [7:0] addr, input logic [7:0] func, input int plen,
		input int fill, input bit corrupt);
		logic [15:0] crc;
		int          at;
		frame_bytes.delete();
		frame_bytes.push_back(addr);
		frame_bytes.push_back(func);
		repeat (plen) begin
			frame_bytes.push_back(fill < 0 ? 8'($urandom_range(0, 255)) : 8'(fill));
		end
		crc = CRC_INIT;
		foreach (frame_bytes[i]) begin
			crc = crc_update(crc, frame_bytes[i]);
		end
		if (cfg_shadow.crc_high_first) begin
			frame_bytes.push_back(crc[15:8]);
			frame_bytes.push_back(crc[7:0]);
		end else begin
			frame_bytes.push_back(crc[7:0]);
			frame_bytes.push_back(crc[15:8]);
		end
		if (corrupt) begin
			at = $urandom_range(0, frame_bytes.size() - 1);
			frame_bytes[at][$urandom_range(0, 7)] ^= 1'b1;
		end
	endtask

	task automatic send_noise(input int len);
		frame_bytes.delete();
		repeat (len) begin
			frame_bytes.push_back(8'($urandom_range(0, 255)));
		end
		send_frame();
	endtask

	task automatic wait_idle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_DEVICE_ADDRESS: cfg_shadow.device_address       = val;
			REG_EXPECTED_FUNC:  cfg_shadow.expected_function    = val[6:0];
			REG_PAYLOAD_LEN:    cfg_shadow.expected_payload_len = val;
			REG_CRC_HIGH_FIRST: cfg_shadow.crc_high_first       = val[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_config(input logic [7:0] addr, input logic [7:0] func, input logic [7:0] len,
		input logic [7:0] order);
		wait_idle();
		write_reg(REG_DEVICE_ADDRESS, addr);
		write_reg(REG_EXPECTED_FUNC, func);
		write_reg(REG_PAYLOAD_LEN, len);
		write_reg(REG_CRC_HIGH_FIRST, order);
	endtask

	task automatic test_reset_settings();
		build_frame(8'h01, 8'h03, 0, -1, 1'b0);
		send_frame();
		build_frame(8'h01, 8'h03, 2, -1, 1'b0);
		send_frame();
	endtask

	task automatic test_short_frames();
		send_noise(1);
		send_noise(2);
		send_noise(3);
		build_frame(8'h01, 8'h83, 0, -1, 1'b0);
		send_frame();
	endtask

	task automatic test_status_codes();
		set_config(8'hFF, 8'hFF, 8'd3, 8'hFE);
		build_frame(8'hFF, 8'h7F, 3, 8'hFF, 1'b0);
		send_frame();
		build_frame(8'hFF, 8'h7F, 3, -1, 1'b1);
		send_frame();
		build_frame(8'h00, 8'h7F, 3, -1, 1'b1);
		send_frame();
		build_frame(8'h00, 8'h7F, 3, -1, 1'b0);
		send_frame();
		build_frame(8'hFF, 8'hFF, 1, -1, 1'b0);
		send_frame();
		build_frame(8'hFF, 8'h00, 3, -1, 1'b0);
		send_frame();
		build_frame(8'hFF, 8'h7F, 1, -1, 1'b0);
		send_frame();
		set_config(8'h00, 8'h80, 8'd0, 8'h01);
		build_frame(8'h00, 8'h00, 0, 8'h00, 1'b0);
		send_frame();
		build_frame(8'h00, 8'h80, 1, 8'h5A, 1'b0);
		send_frame();
	endtask

	task automatic test_overlong_frame();
		set_config(8'h01, 8'h03, 8'd252, 8'h01);
		build_frame(8'h01, 8'h03, 253, -1, 1'b0);
		send_frame();
		build_frame(8'h01, 8'h03, 254, -1, 1'b0);
		send_frame();
	endtask

	task automatic test_random_frames();
		int          stop_at;
		int          phase_end;
		int          frames;
		int          kind;
		int          plen;
		logic [7:0]  addr;
		logic [7:0]  func;
		logic [7:0]  len;
		stop_at = bytes_accepted + RANDOM_ITEMS;
		frames  = 0;
		while (bytes_accepted < stop_at) begin
			addr = ($urandom_range(0, 2) == 0) ? ($urandom_range(0, 1) ? 8'hFF : 8'h00)
			                                   : 8'($urandom_range(0, 255));
			func = ($urandom_range(0, 2) == 0) ? {1'($urandom_range(0, 1)),
			                                      ($urandom_range(0, 1) ? 7'h7F : 7'h00)}
			                                   : 8'($urandom_range(0, 255));
			case ($urandom_range(0, 9))
				0:       len = 8'd252;
				1:       len = 8'd0;
				default: len = 8'($urandom_range(0, 8));
			endcase
			set_config(addr, func, len, 8'($urandom_range(0, 255)));
			phase_end = bytes_accepted + PHASE_ITEMS;
			while (bytes_accepted < phase_end && bytes_accepted < stop_at) begin
				if ($urandom_range(0, 7) == 0) tx_idle_on = !tx_idle_on;
				if ($urandom_range(0, 7) == 0) rx_idle_on = !rx_idle_on;
				plen = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 10)
				                                   : cfg_shadow.expected_payload_len;
				kind = $urandom_range(0, 9);
				case (kind)
					6: build_frame(cfg_shadow.device_address, {1'b1, cfg_shadow.expected_function},
						$urandom_range(0, 3), -1, 1'b0);
					7: build_frame($urandom_range(0, 1) ? 8'($urandom_range(0, 255))
					                                    : cfg_shadow.device_address,
						8'($urandom_range(0, 255)), $urandom_range(0, 4), -1, 1'b0);
					8: build_frame(cfg_shadow.device_address, {1'b0, cfg_shadow.expected_function},
						plen, -1, 1'b1);
					default: build_frame(cfg_shadow.device_address,
						{1'b0, cfg_shadow.expected_function}, plen, -1, 1'b0);
				endcase
				if (kind == 9 && $urandom_range(0, 1)) begin
					send_noise($urandom_range(1, 8));
				end else begin
					send_frame();
				end
				frames++;
				if (frames % 15 == 0) begin
					wait_idle();
				end
			end
		end
	endtask

	initial begin
		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tdata    = 8'h00;
		s_tlast    = 1'b0;
		cfg_valid  = 1'b0;
		cfg_index  = REG_DEVICE_ADDRESS;
		cfg_data   = 8'h00;
		mismatches = 0;
		bytes_accepted = 0;
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		cfg_shadow.device_address       = 8'd1;
		cfg_shadow.expected_function    = 7'd3;
		cfg_shadow.expected_payload_len = 8'd0;
		cfg_shadow.crc_high_first       = 1'b1;
		clear_frame_state();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_settings();
		test_short_frames();
		test_status_codes();
		test_overlong_frame();
		test_random_frames();

		wait_idle();
		if (mismatches == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
